// ===== rtl/core/ftc_pkg.sv =====
// ============================================================================
// ftc_pkg - force/torque calibration shared types and constants
// Beat layouts, fixed-point widths and the 6x6 calibration table.
// ============================================================================
`default_nettype none

package ftc_pkg;

  localparam int NumCh     = 6;
  localparam int CodeW     = 16;            // channel and bias code width
  localparam int DiffW     = CodeW + 1;     // bias-corrected difference
  localparam int CoefW     = 24;            // coefficient, 20 fraction bits
  localparam int ProdW     = 41;            // one coefficient times one difference
  localparam int PairW     = ProdW + 1;     // sum of two products
  localparam int SumW      = 44;            // full row sum
  localparam int WideW     = 52;            // row sum after lever-arm shift, doubled
  localparam int RndW      = 55;            // times five, plus rounding half
  localparam int OutW      = 32;
  localparam int FracShift = 19;
  localparam int CfgIdxW   = 3;

  localparam logic signed [8:0] ArmK  = 9'sd189;  // 2 * 94.5
  localparam logic signed [3:0] ScaleK = 4'sd5;
  localparam longint RoundHalf = 64'sd262144;     // 2^(FracShift-1)
  localparam longint OutMax    = 64'sd2147483647;
  localparam longint OutMin    = -64'sd2147483648;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef diff_t [NumCh-1:0] diff_vec_t;
  typedef sum_t  [NumCh-1:0] sum_vec_t;

  // Rows: force_x, force_y, force_z, torque_x, torque_y, torque_z.
  localparam coef_t Cal [NumCh][NumCh] = '{
    '{  -24'sd369,     24'sd21467,  -24'sd27609, -24'sd722445,   24'sd396,     24'sd744498 },
    '{  -24'sd20124,   24'sd879759, -24'sd18012, -24'sd394722,   24'sd4701,   -24'sd455253 },
    '{   24'sd870367,  24'sd4792,    24'sd874053,  24'sd22099,   24'sd841940, -24'sd1416   },
    '{  -24'sd331668,  24'sd5307240, 24'sd4838318,-24'sd2255172,-24'sd4552801,-24'sd2758566 },
    '{ -24'sd5578428, -24'sd164249,  24'sd2931998, 24'sd4410860, 24'sd2915631,-24'sd4459436 },
    '{  -24'sd58972,   24'sd3241534, 24'sd128033,  24'sd3084352, 24'sd6162,    24'sd3245000 }
  };

  typedef struct packed {
    logic signed [CodeW-1:0] volt_ch0;
    logic signed [CodeW-1:0] volt_ch1;
    logic signed [CodeW-1:0] volt_ch2;
    logic signed [CodeW-1:0] volt_ch3;
    logic signed [CodeW-1:0] volt_ch4;
    logic signed [CodeW-1:0] volt_ch5;
  } ftc_in_t;

  typedef struct packed {
    logic signed [OutW-1:0] force_x;
    logic signed [OutW-1:0] force_y;
    logic signed [OutW-1:0] force_z;
    logic signed [OutW-1:0] torque_x;
    logic signed [OutW-1:0] torque_y;
    logic signed [OutW-1:0] torque_z;
  } ftc_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/ftc_bias_sub.sv =====
// ============================================================================
// ftc_bias_sub - bias registers and offset removal
// Holds the six bias registers and registers the 17-bit differences.
// ============================================================================
`default_nettype none

module ftc_bias_sub (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [ftc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [ftc_pkg::CodeW-1:0]    cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire ftc_pkg::ftc_in_t             in_data,
  output logic                              dn_valid,
  input  wire logic                         dn_ready,
  output ftc_pkg::diff_vec_t                dn_diff
);

  logic signed [ftc_pkg::CodeW-1:0] bias [ftc_pkg::NumCh];
  logic signed [ftc_pkg::CodeW-1:0] volt [ftc_pkg::NumCh];
  logic                             adv;

  assign volt[0] = in_data.volt_ch0;
  assign volt[1] = in_data.volt_ch1;
  assign volt[2] = in_data.volt_ch2;
  assign volt[3] = in_data.volt_ch3;
  assign volt[4] = in_data.volt_ch4;
  assign volt[5] = in_data.volt_ch5;

  assign adv      = !dn_valid || dn_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < ftc_pkg::NumCh; j++) begin
        bias[j] <= '0;
      end
    end else if (cfg_we && (cfg_index < ftc_pkg::CfgIdxW'(ftc_pkg::NumCh))) begin
      bias[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= in_valid;
    end
  end

  // Sign-extend both sides so the difference never wraps.
  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      for (int j = 0; j < ftc_pkg::NumCh; j++) begin
        dn_diff[j] <= ftc_pkg::DiffW'(volt[j]) - ftc_pkg::DiffW'(bias[j]);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ftc_matrix.sv =====
// ============================================================================
// ftc_matrix - 6x6 calibration product
// Three stages: 36 products, pair sums, row sums.
// ============================================================================
`default_nettype none

module ftc_matrix (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire ftc_pkg::diff_vec_t   up_diff,
  output logic                      dn_valid,
  input  wire logic                 dn_ready,
  output ftc_pkg::sum_vec_t         dn_sum
);

  localparam int NumPair = ftc_pkg::NumCh / 2;

  logic signed [ftc_pkg::ProdW-1:0] prod [ftc_pkg::NumCh][ftc_pkg::NumCh];
  logic signed [ftc_pkg::PairW-1:0] pair [ftc_pkg::NumCh][NumPair];
  logic v_prod, v_pair;
  logic adv_prod, adv_pair, adv_sum;

  assign adv_sum  = !dn_valid || dn_ready;
  assign adv_pair = !v_pair || adv_sum;
  assign adv_prod = !v_prod || adv_pair;
  assign up_ready = adv_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_prod   <= 1'b0;
      v_pair   <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (adv_prod) begin
        v_prod <= up_valid;
      end
      if (adv_pair) begin
        v_pair <= v_prod;
      end
      if (adv_sum) begin
        dn_valid <= v_pair;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_prod && up_valid) begin
      for (int i = 0; i < ftc_pkg::NumCh; i++) begin
        for (int j = 0; j < ftc_pkg::NumCh; j++) begin
          prod[i][j] <= ftc_pkg::ProdW'(ftc_pkg::Cal[i][j]) *
                        ftc_pkg::ProdW'($signed(up_diff[j]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_pair && v_prod) begin
      for (int i = 0; i < ftc_pkg::NumCh; i++) begin
        for (int k = 0; k < NumPair; k++) begin
          pair[i][k] <= ftc_pkg::PairW'(prod[i][2*k]) + ftc_pkg::PairW'(prod[i][2*k+1]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_sum && v_pair) begin
      for (int i = 0; i < ftc_pkg::NumCh; i++) begin
        dn_sum[i] <= ftc_pkg::SumW'(pair[i][0]) + ftc_pkg::SumW'(pair[i][1]) +
                     ftc_pkg::SumW'(pair[i][2]);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ftc_finish.sv =====
// ============================================================================
// ftc_finish - reference shift, scaling, rounding and saturation
// Two stages: lever-arm correction, then scale, round and clip to 32 bits.
// ============================================================================
`default_nettype none

module ftc_finish (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire ftc_pkg::sum_vec_t   up_sum,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ftc_pkg::ftc_out_t        out_data
);

  logic signed [ftc_pkg::WideW-1:0] w   [ftc_pkg::NumCh];
  logic signed [ftc_pkg::RndW-1:0]  rnd [ftc_pkg::NumCh];
  logic signed [ftc_pkg::RndW-1:0]  q   [ftc_pkg::NumCh];
  logic signed [ftc_pkg::OutW-1:0]  sat [ftc_pkg::NumCh];
  logic signed [ftc_pkg::WideW-1:0] a   [ftc_pkg::NumCh];
  logic v_w, adv_w, adv_out;

  assign adv_out  = !out_valid || out_ready;
  assign adv_w    = !v_w || adv_out;
  assign up_ready = adv_w;

  always_comb begin
    for (int i = 0; i < ftc_pkg::NumCh; i++) begin
      a[i] = ftc_pkg::WideW'($signed(up_sum[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_w       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_w) begin
        v_w <= up_valid;
      end
      if (adv_out) begin
        out_valid <= v_w;
      end
    end
  end

  // Move the torque reference point: tx += 94.5 fy, ty -= 94.5 fx (doubled).
  always_ff @(posedge clk) begin
    if (adv_w && up_valid) begin
      w[0] <= a[0] <<< 1;
      w[1] <= a[1] <<< 1;
      w[2] <= a[2] <<< 1;
      w[3] <= (a[3] <<< 1) + a[1] * ftc_pkg::WideW'(ftc_pkg::ArmK);
      w[4] <= (a[4] <<< 1) - a[0] * ftc_pkg::WideW'(ftc_pkg::ArmK);
      w[5] <= a[5] <<< 1;
    end
  end

  // Scale by 5 / 2^19, round half up, clip to the 32-bit range.
  always_comb begin
    for (int i = 0; i < ftc_pkg::NumCh; i++) begin
      rnd[i] = ftc_pkg::RndW'(w[i]) * ftc_pkg::RndW'(ftc_pkg::ScaleK) +
               ftc_pkg::RndW'(ftc_pkg::RoundHalf);
      q[i]   = rnd[i] >>> ftc_pkg::FracShift;
      if (q[i] > ftc_pkg::RndW'(ftc_pkg::OutMax)) begin
        sat[i] = ftc_pkg::OutW'(ftc_pkg::OutMax);
      end else if (q[i] < ftc_pkg::RndW'(ftc_pkg::OutMin)) begin
        sat[i] = ftc_pkg::OutW'(ftc_pkg::OutMin);
      end else begin
        sat[i] = q[i][ftc_pkg::OutW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && v_w) begin
      out_data.force_x  <= sat[0];
      out_data.force_y  <= sat[1];
      out_data.force_z  <= sat[2];
      out_data.torque_x <= sat[3];
      out_data.torque_y <= sat[4];
      out_data.torque_z <= sat[5];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/force_torque_calibration.sv =====
// ============================================================================
// force_torque_calibration - six-axis force/torque sensor calibration
// Bias removal, 6x6 calibration matrix and torque reference shift.
// ============================================================================
// The block takes one sample of six signed 16-bit strain-gauge codes per beat
// and returns one beat of three forces and three torques, signed 32-bit with
// 16 fraction bits, rounded half up and saturated. One sample is accepted
// every clock and one result leaves every clock while out_ready is high;
// each sample passes through six register stages: bias subtraction, the 36
// coefficient products, pair sums, row sums, the lever-arm correction, and
// the scale/round/clip output register. Each stage holds its own valid bit
// and moves on whenever the stage after it is empty or moving, so a stalled
// output only blocks the input once every stage is full.
// Bias registers 0..5 are written through cfg_we/cfg_index/cfg_data (low 16
// bits kept, indexes above 5 ignored); write them only while the pipeline is
// empty.
`default_nettype none

module force_torque_calibration (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [ftc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [ftc_pkg::CodeW-1:0]    cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire ftc_pkg::ftc_in_t             in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output ftc_pkg::ftc_out_t                 out_data
);

  // Bias-corrected differences between offset stage and matrix.
  logic               diff_valid, diff_ready;
  ftc_pkg::diff_vec_t diff;

  // Raw row sums between matrix and finishing stages.
  logic               sum_valid, sum_ready;
  ftc_pkg::sum_vec_t  sum;

  ftc_bias_sub u_bias_sub (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .dn_valid  (diff_valid),
    .dn_ready  (diff_ready),
    .dn_diff   (diff)
  );

  ftc_matrix u_matrix (
    .clk      (clk),
    .rst      (rst),
    .up_valid (diff_valid),
    .up_ready (diff_ready),
    .up_diff  (diff),
    .dn_valid (sum_valid),
    .dn_ready (sum_ready),
    .dn_sum   (sum)
  );

  // Apply the reference shift and drive the output register.
  ftc_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (sum_valid),
    .up_ready  (sum_ready),
    .up_sum    (sum),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== verif/ftc_wrench_pkg.sv =====
// ----------------------------------------------------------------------------
// ftc_wrench_pkg - calibration predictor and result checker
// Holds a bit-exact model of the bias removal, the calibration matrix, the
// torque reference shift and the output rounding. A checker class keeps the
// bias copy, queues the predicted wrench for each accepted sample and
// compares output beats with that queue in order.
// ----------------------------------------------------------------------------
package ftc_wrench_pkg;

  import ftc_pkg::*;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BIAS_CH0, REG_BIAS_CH1, REG_BIAS_CH2,
    REG_BIAS_CH3, REG_BIAS_CH4, REG_BIAS_CH5,
    REG_SPARE6, REG_SPARE7
  } bias_reg_e;

  // Coefficients with 20 fraction bits.
  // Rows: force x/y/z, then torque x/y/z about the sensor origin.
  localparam longint GaugeMatrix [6][6] = '{
    '{    -369,   21467,  -27609,  -722445,      396,   744498 },
    '{  -20124,  879759,  -18012,  -394722,     4701,  -455253 },
    '{  870367,    4792,  874053,    22099,   841940,    -1416 },
    '{ -331668, 5307240, 4838318, -2255172, -4552801, -2758566 },
    '{-5578428, -164249, 2931998,  4410860,  2915631, -4459436 },
    '{  -58972, 3241534,  128033,  3084352,     6162,  3245000 }
  };

  localparam longint LeverArmX2 = 189;   // twice the 94.5 shift
  localparam longint CodeScale  = 5;
  localparam int     DropBits   = 19;
  localparam longint SatHigh    = 64'sd2147483647;
  localparam longint SatLow     = -64'sd2147483648;

  class wrench_checker;

    logic signed [CodeW-1:0] bias [NumCh];
    ftc_out_t expected_wrench [$];
    int mismatches;
    int beats_seen;

    function new();
      foreach (bias[k]) bias[k] = '0;
      mismatches = 0;
      beats_seen = 0;
    endfunction

    // Indexes past the last bias register are dropped, as in the block.
    function void write_reg(bias_reg_e idx, logic [CodeW-1:0] value);
      if (idx <= REG_BIAS_CH5) bias[idx] = value;
    endfunction

    function int pending();
      return expected_wrench.size();
    endfunction

    // Scale to 16 fraction bits, round half up, clip to 32 bits.
    function logic signed [OutW-1:0] scale_round(longint w);
      longint q;
      q = (w * CodeScale + (longint'(1) <<< (DropBits - 1))) >>> DropBits;
      if (q > SatHigh) q = SatHigh;
      if (q < SatLow) q = SatLow;
      return q[OutW-1:0];
    endfunction

    function ftc_out_t calibrate(ftc_in_t s);
      logic signed [CodeW-1:0] volt [NumCh];
      longint diff [NumCh];
      longint acc [NumCh];
      longint wide [NumCh];
      ftc_out_t r;
      volt = '{s.volt_ch0, s.volt_ch1, s.volt_ch2, s.volt_ch3, s.volt_ch4, s.volt_ch5};
      // 17-bit difference, neither wrapped nor clipped
      for (int j = 0; j < NumCh; j++) diff[j] = longint'(volt[j]) - longint'(bias[j]);
      for (int i = 0; i < NumCh; i++) begin
        acc[i] = 0;
        for (int j = 0; j < NumCh; j++) acc[i] += GaugeMatrix[i][j] * diff[j];
        wide[i] = 2 * acc[i];
      end
      // move the torque reference point along the lever arm
      wide[3] = 2 * acc[3] + LeverArmX2 * acc[1];
      wide[4] = 2 * acc[4] - LeverArmX2 * acc[0];
      r.force_x  = scale_round(wide[0]);
      r.force_y  = scale_round(wide[1]);
      r.force_z  = scale_round(wide[2]);
      r.torque_x = scale_round(wide[3]);
      r.torque_y = scale_round(wide[4]);
      r.torque_z = scale_round(wide[5]);
      return r;
    endfunction

    function void note_sample(ftc_in_t s);
      expected_wrench.push_back(calibrate(s));
    endfunction

    task report(string msg);
      if (mismatches < 100) $display("%0t ns: beat %0d: %s", $time, beats_seen, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic signed [OutW-1:0] got, logic signed [OutW-1:0] want);
      if (got !== want) report($sformatf("%s is %0d, predicted %0d", name, got, want));
    endtask

    task check_wrench(ftc_out_t got);
      ftc_out_t want;
      if (expected_wrench.size() == 0) begin
        report("output beat with no sample outstanding");
      end else begin
        want = expected_wrench.pop_front();
        compare_field("force_x", got.force_x, want.force_x);
        compare_field("force_y", got.force_y, want.force_y);
        compare_field("force_z", got.force_z, want.force_z);
        compare_field("torque_x", got.torque_x, want.torque_x);
        compare_field("torque_y", got.torque_y, want.torque_y);
        compare_field("torque_z", got.torque_z, want.torque_z);
      end
      beats_seen++;
    endtask

  endclass

endpackage

// ===== verif/force_torque_calibration_tb.sv =====
// ----------------------------------------------------------------------------
// force_torque_calibration_tb - calibration pipeline testbench
// Drives sample beats through the calibration block under several bias
// settings, with random gaps on the input and random stalls on the output,
// and checks every result beat against a bit-exact predictor.
// ----------------------------------------------------------------------------
module force_torque_calibration_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ftc_pkg::*;
  import ftc_wrench_pkg::*;

  localparam int PipeDepth      = 6;     // input beat to output beat
  localparam int RandomPerPhase = 190;
  localparam int NumPhases      = 8;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  bias_reg_e         cfg_index;
  logic [CodeW-1:0]  cfg_data;
  logic              in_valid;
  logic              in_ready;
  ftc_in_t           in_data;
  logic              out_valid;
  logic              out_ready;
  ftc_out_t          out_data;

  // Idling switches, flipped per phase so that some phases run flat out.
  bit tx_idle;
  bit rx_idle;

  wrench_checker board;

  force_torque_calibration dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous bound: several times what the slowest correct run needs, even
  // with the longest gaps and stalls on every beat.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Idle stretch: mostly short, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Lean on the code extremes, zero and minus one; otherwise any pattern.
  function automatic logic signed [CodeW-1:0] pick_code();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return CodeW'($urandom);
    endcase
  endfunction

  function automatic ftc_in_t random_sample();
    ftc_in_t s;
    for (int ch = 0; ch < NumCh; ch++) s[(NumCh-1-ch)*CodeW +: CodeW] = pick_code();
    return s;
  endfunction

  function automatic ftc_in_t uniform_sample(logic signed [CodeW-1:0] v);
    ftc_in_t s;
    for (int ch = 0; ch < NumCh; ch++) s[(NumCh-1-ch)*CodeW +: CodeW] = v;
    return s;
  endfunction

  // Only one channel carries a value; the others sit at zero.
  function automatic ftc_in_t lone_channel(int ch, logic signed [CodeW-1:0] v);
    ftc_in_t s;
    s = '0;
    s[(NumCh-1-ch)*CodeW +: CodeW] = v;
    return s;
  endfunction

  // Offer one sample beat and hold it until the block takes it. Entered and
  // left on a falling edge; valid stays high for a back-to-back beat.
  task automatic send_sample(ftc_in_t s);
    int gap;
    gap = 0;
    if (tx_idle && $urandom_range(0, 99) < 35) gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    board.note_sample(s);
    @(negedge clk);
  endtask

  // Write the six bias registers, then optionally poke the two spare indexes,
  // which the block must drop.
  task automatic load_biases(input logic signed [CodeW-1:0] vals [NumCh], input bit spare);
    for (int k = 0; k < NumCh; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= bias_reg_e'(k);
      cfg_data  <= vals[k];
      @(posedge clk);
      board.write_reg(bias_reg_e'(k), vals[k]);
      @(negedge clk);
    end
    if (spare) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_SPARE6;
      cfg_data  <= CodeW'($urandom);
      @(posedge clk);
      board.write_reg(REG_SPARE6, cfg_data);
      @(negedge clk);
      cfg_index <= REG_SPARE7;
      cfg_data  <= CodeW'($urandom);
      @(posedge clk);
      board.write_reg(REG_SPARE7, cfg_data);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Drop valid, wait for every predicted beat, then let the pipe empty out.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (PipeDepth + 2) @(negedge clk);
  endtask

  task automatic set_idling();
    tx_idle = ($urandom_range(0, 3) != 0);
    rx_idle = ($urandom_range(0, 3) != 0);
  endtask

  // Output side: hold ready low for random stretches, or never when idling
  // is off for this phase.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (rx_idle && $urandom_range(0, 99) < 25) begin
        out_ready  <= 1'b0;
        stall_left = idle_len() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check each result beat as it is taken.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_wrench(out_data);
  end

  initial begin
    logic signed [CodeW-1:0] bias_set [NumCh];
    ftc_in_t s;
    board     = new();
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_BIAS_CH0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    tx_idle   = 1'b0;
    rx_idle   = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed beats on the reset biases: zero, full scale both ways, minus
    // one, each channel alone at full scale, and alternating bit patterns.
    send_sample(uniform_sample('0));
    send_sample(uniform_sample(16'sh7fff));
    send_sample(uniform_sample(16'sh8000));
    send_sample(uniform_sample('1));
    for (int ch = 0; ch < NumCh; ch++) send_sample(lone_channel(ch, 16'sh7fff));
    send_sample(uniform_sample(16'sh5555));
    send_sample(uniform_sample(16'shaaaa));

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        0: foreach (bias_set[k]) bias_set[k] = 16'sh7fff;
        1: foreach (bias_set[k]) bias_set[k] = 16'sh8000;
        2: foreach (bias_set[k]) bias_set[k] = (k % 2) ? 16'sh8000 : 16'sh7fff;
        NumPhases - 1: foreach (bias_set[k]) bias_set[k] = '0;
        default: foreach (bias_set[k]) bias_set[k] = pick_code();
      endcase
      load_biases(bias_set, ph % 2 == 0);
      @(negedge clk);

      // Differences at the far ends of the 17-bit range, where the
      // subtraction must neither wrap nor clip.
      case (ph)
        0: begin
          send_sample(uniform_sample(16'sh8000));
          send_sample(uniform_sample(16'sh7fff));
        end
        1: begin
          send_sample(uniform_sample(16'sh7fff));
          send_sample(uniform_sample(16'sh8000));
        end
        2: begin
          for (int ch = 0; ch < NumCh; ch++)
            s[(NumCh-1-ch)*CodeW +: CodeW] = (ch % 2) ? 16'sh7fff : 16'sh8000;
          send_sample(s);
        end
        default: ;
      endcase

      set_idling();
      repeat (RandomPerPhase) send_sample(random_sample());
    end

    drain();
    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
